@@ rtl/arc_point_evaluator_defines.svh @@
// Assertion macros shared by the arc point evaluator RTL.
`ifndef ARC_POINT_EVALUATOR_DEFINES_SVH
`define ARC_POINT_EVALUATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define APE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arc_point_evaluator: implication check failed");

// Condition never true.
`define APE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("arc_point_evaluator: forbidden condition seen");

`else

`define APE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define APE_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/ape_pkg.sv @@
// Types and constants of the arc point evaluator.
package ape_pkg;

    localparam int CFG_IW = 3;
    localparam int CFG_DW = 64;

    localparam logic [CFG_IW-1:0] REG_CENTER_X    = 3'd0;
    localparam logic [CFG_IW-1:0] REG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_AXES_PACKED = 3'd2;
    localparam logic [CFG_IW-1:0] REG_RADIUS      = 3'd3;
    localparam logic [CFG_IW-1:0] REG_START_ANGLE = 3'd4;
    localparam logic [CFG_IW-1:0] REG_END_ANGLE   = 3'd5;

    localparam logic [31:0] RST_CENTER_X    = 32'd0;
    localparam logic [31:0] RST_CENTER_Y    = 32'd0;
    localparam logic [63:0] RST_AXES_PACKED = 64'h0000_0000_4000_4000;
    localparam logic [30:0] RST_RADIUS      = 31'd65536;
    localparam logic [31:0] RST_START_ANGLE = 32'd0;
    localparam logic [31:0] RST_END_ANGLE   = 32'd26353589;

    localparam int TW = 17;
    localparam logic [TW-1:0] T_ONE = 17'h10000;

    // Angle constants, Q8.24
    localparam longint ANG_TWO_PI  = 105414357;
    localparam longint ANG_PI      = 52707179;
    localparam longint ANG_HALF_PI = 26353589;

    // Modulo reduction: offset makes any int32 angle positive, then
    // MOD_STEPS conditional subtracts of 2*pi scaled by powers of two.
    localparam int     MW         = 33;
    localparam int     MOD_STEPS  = 6;
    localparam longint MOD_WRAPS  = 21;
    localparam logic [MW-1:0] MOD_OFFSET = MW'(MOD_WRAPS * ANG_TWO_PI);

    localparam int AW = 28;   // folded angle, signed
    localparam int ZFRAC = 6; // Q8.24 to Q2.30

    localparam int ZW = 34;
    localparam logic signed [ZW-1:0] GAIN_Q30 = 34'sd652032874;

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    typedef struct packed {
        logic signed [ZW-1:0] x;
        logic signed [ZW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
    } cordic_tok_t;

endpackage

@@ rtl/ape_mod_cell.sv @@
// One conditional-subtract cell of the angle modulo chain.
module ape_mod_cell #(
    parameter int K = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_in,
    input  logic [ape_pkg::MW-1:0] rem_in,
    output logic                  valid_out,
    output logic [ape_pkg::MW-1:0] rem_out
);
    import ape_pkg::*;

    localparam logic [MW-1:0] STEP = MW'(ANG_TWO_PI <<< K);

    logic          valid_reg;
    logic [MW-1:0] rem_reg;
    logic [MW-1:0] rem_next;

    always_comb
    begin
        if (rem_in >= STEP)
        begin
            rem_next = rem_in - STEP;
        end
        else
        begin
            rem_next = rem_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;

endmodule

@@ rtl/ape_cordic_cell.sv @@
// One rotation-mode CORDIC micro-rotation cell.
module ape_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  ape_pkg::cordic_tok_t tok_in,
    output logic                 valid_out,
    output ape_pkg::cordic_tok_t tok_out
);
    import ape_pkg::*;

    localparam logic signed [ZW-1:0] AT = $signed(ZW'(ATAN_Q30[STAGE]));

    logic        valid_reg;
    cordic_tok_t tok_reg;
    cordic_tok_t tok_next;

    logic signed [ZW-1:0] dx;
    logic signed [ZW-1:0] dy;

    always_comb
    begin
        dx = $signed(tok_in.y) >>> STAGE;
        dy = $signed(tok_in.x) >>> STAGE;
        tok_next.neg = tok_in.neg;
        if (!tok_in.z[ZW-1])
        begin
            tok_next.x = tok_in.x - dx;
            tok_next.y = tok_in.y + dy;
            tok_next.z = tok_in.z - AT;
        end
        else
        begin
            tok_next.x = tok_in.x + dx;
            tok_next.y = tok_in.y - dy;
            tok_next.z = tok_in.z + AT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign valid_out = valid_reg;
    assign tok_out   = tok_reg;

endmodule

@@ rtl/ape_scale.sv @@
// Output pipeline: sign fix, radius and axis scaling, center offset, saturation.
module ape_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  ape_pkg::cordic_tok_t tok_in,
    input  logic [30:0]          radius,
    input  logic [63:0]          axes_packed,
    input  logic [31:0]          center_x,
    input  logic [31:0]          center_y,
    output logic                 done,
    output logic signed [31:0]   point_x,
    output logic signed [31:0]   point_y
);
    import ape_pkg::*;

    localparam int PW = 32;
    localparam int RW = 33;
    localparam int QW = RW + 16;
    localparam int SW = 37;
    localparam int NST = 5;
    localparam logic signed [2*PW-1:0] RND30 = 64'sh2000_0000;
    localparam logic signed [QW-1:0]   RND14 = QW'(64'sh2000);
    localparam logic signed [SW-1:0]   SAT_MAX = SW'(64'sh7FFF_FFFF);
    localparam logic signed [SW-1:0]   SAT_MIN = -SW'(64'sh8000_0000);

    logic [NST-1:0] v_reg;

    logic signed [ZW-1:0]   xn;
    logic signed [ZW-1:0]   yn;
    logic signed [PW-1:0]   xs_reg;
    logic signed [PW-1:0]   ys_reg;
    logic signed [PW-1:0]   rs;
    logic signed [2*PW-1:0] xr_reg;
    logic signed [2*PW-1:0] yr_reg;
    logic signed [2*PW-1:0] xr_rnd;
    logic signed [2*PW-1:0] yr_rnd;
    logic signed [RW-1:0]   cr_reg;
    logic signed [RW-1:0]   sr_reg;
    logic signed [QW-1:0]   pux_reg;
    logic signed [QW-1:0]   pvx_reg;
    logic signed [QW-1:0]   puy_reg;
    logic signed [QW-1:0]   pvy_reg;
    logic signed [QW-1:0]   tux;
    logic signed [QW-1:0]   tvx;
    logic signed [QW-1:0]   tuy;
    logic signed [QW-1:0]   tvy;
    logic signed [SW-1:0]   sx;
    logic signed [SW-1:0]   sy;
    logic signed [PW-1:0]   px_next;
    logic signed [PW-1:0]   py_next;
    logic signed [PW-1:0]   px_reg;
    logic signed [PW-1:0]   py_reg;

    always_comb
    begin
        xn = tok_in.neg ? -tok_in.x : tok_in.x;
        yn = tok_in.neg ? -tok_in.y : tok_in.y;
        rs = $signed({1'b0, radius});
        xr_rnd = (xr_reg + RND30) >>> 30;
        yr_rnd = (yr_reg + RND30) >>> 30;
        tux = (pux_reg + RND14) >>> 14;
        tvx = (pvx_reg + RND14) >>> 14;
        tuy = (puy_reg + RND14) >>> 14;
        tvy = (pvy_reg + RND14) >>> 14;
        sx = SW'($signed(center_x)) + SW'(tux) + SW'(tvx);
        sy = SW'($signed(center_y)) + SW'(tuy) + SW'(tvy);
        if (sx > SAT_MAX)
        begin
            px_next = SAT_MAX[PW-1:0];
        end
        else if (sx < SAT_MIN)
        begin
            px_next = SAT_MIN[PW-1:0];
        end
        else
        begin
            px_next = sx[PW-1:0];
        end
        if (sy > SAT_MAX)
        begin
            py_next = SAT_MAX[PW-1:0];
        end
        else if (sy < SAT_MIN)
        begin
            py_next = SAT_MIN[PW-1:0];
        end
        else
        begin
            py_next = sy[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[NST-2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        xs_reg  <= xn[PW-1:0];
        ys_reg  <= yn[PW-1:0];
        xr_reg  <= xs_reg * rs;
        yr_reg  <= ys_reg * rs;
        cr_reg  <= xr_rnd[RW-1:0];
        sr_reg  <= yr_rnd[RW-1:0];
        pux_reg <= cr_reg * $signed(axes_packed[15:0]);
        puy_reg <= cr_reg * $signed(axes_packed[31:16]);
        pvx_reg <= sr_reg * $signed(axes_packed[47:32]);
        pvy_reg <= sr_reg * $signed(axes_packed[63:48]);
        px_reg  <= px_next;
        py_reg  <= py_next;
    end

    assign done    = v_reg[NST-1];
    assign point_x = px_reg;
    assign point_y = py_reg;

endmodule

@@ rtl/arc_point_evaluator.sv @@
// Top level of the arc point evaluator: config registers, angle path, cell chains.
`include "arc_point_evaluator_defines.svh"

// Fully pipelined: a new param_t may be started every cycle (busy stays low)
// and each one yields exactly one point on done, in order. The pipeline is
// the interpolation multiply register, the angle add register, six cells of
// modulo-2*pi reduction, one fold stage, one CORDIC cell per stage and five
// output stages (sign, radius multiply, round, axis multiply, sum and
// saturate). done is a one-cycle strobe; the receiver cannot stall it, so
// point_x/point_y must be captured in that cycle. Write configuration only
// with no transaction in flight; cfg_ready is always high and writes to
// unknown indexes are dropped.
module arc_point_evaluator #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [16:0]                 param_t,
    output logic                        done,
    output logic signed [31:0]          point_x,
    output logic signed [31:0]          point_y,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ape_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [ape_pkg::CFG_DW-1:0]  cfg_data
);
    import ape_pkg::*;

    localparam int LAT = CORDIC_STAGES + 14;
    localparam logic signed [ZW-1:0] Z_LIM = ZW'(ANG_HALF_PI) <<< ZFRAC;

    logic [31:0] center_x_reg;
    logic [31:0] center_y_reg;
    logic [63:0] axes_reg;
    logic [30:0] radius_reg;
    logic [31:0] start_reg;
    logic [31:0] end_reg;

    logic [TW-1:0]     t_sat;
    logic signed [32:0] diff;
    logic signed [50:0] prod_next;
    logic signed [50:0] prod_reg;
    logic               s0_valid_reg;

    logic signed [50:0] lerp_rnd;
    logic signed [33:0] ang;
    logic signed [33:0] ang_off;
    logic [MW-1:0]      s1_rem_reg;
    logic               s1_valid_reg;

    logic          mod_v [0:MOD_STEPS];
    logic [MW-1:0] mod_r [0:MOD_STEPS];

    logic signed [AW-1:0] a0;
    logic signed [AW-1:0] a1;
    logic signed [AW-1:0] a2;
    logic                 fold_neg;
    logic signed [ZW-1:0] z_ext;
    cordic_tok_t          fold_next;
    logic                 fold_valid_reg;
    cordic_tok_t          fold_tok_reg;

    logic        cv [0:CORDIC_STAGES];
    cordic_tok_t ct [0:CORDIC_STAGES];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= RST_CENTER_X;
            center_y_reg <= RST_CENTER_Y;
            axes_reg     <= RST_AXES_PACKED;
            radius_reg   <= RST_RADIUS;
            start_reg    <= RST_START_ANGLE;
            end_reg      <= RST_END_ANGLE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTER_X:    center_x_reg <= cfg_data[31:0];
                REG_CENTER_Y:    center_y_reg <= cfg_data[31:0];
                REG_AXES_PACKED: axes_reg     <= cfg_data;
                REG_RADIUS:      radius_reg   <= cfg_data[30:0];
                REG_START_ANGLE: start_reg    <= cfg_data[31:0];
                REG_END_ANGLE:   end_reg      <= cfg_data[31:0];
                default:         ;
            endcase
        end
    end

    // Interpolation multiply
    always_comb
    begin
        t_sat = (param_t > T_ONE) ? T_ONE : param_t;
        diff = $signed({end_reg[31], end_reg}) - $signed({start_reg[31], start_reg});
        prod_next = diff * $signed({1'b0, t_sat});
    end

    // Angle add, rounding half up, plus offset to make it positive
    always_comb
    begin
        lerp_rnd = (prod_reg + 51'sd32768) >>> 16;
        ang      = $signed({{2{start_reg[31]}}, start_reg}) + lerp_rnd[33:0];
        ang_off  = ang + $signed({1'b0, MOD_OFFSET});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= start && !busy;
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        s1_rem_reg <= ang_off[MW-1:0];
    end

    assign mod_v[0] = s1_valid_reg;
    assign mod_r[0] = s1_rem_reg;

    for (genvar g = 0; g < MOD_STEPS; g++)
    begin : g_mod
        ape_mod_cell #(
            .K(MOD_STEPS - 1 - g)
        ) u_mod (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid_in (mod_v[g]),
            .rem_in   (mod_r[g]),
            .valid_out(mod_v[g+1]),
            .rem_out  (mod_r[g+1])
        );
    end

    // Fold [0, 2pi) into [-pi/2, pi/2] with a sign flag
    always_comb
    begin
        a0 = $signed({1'b0, mod_r[MOD_STEPS][AW-2:0]});
        if (a0 > AW'(ANG_PI))
        begin
            a1 = a0 - AW'(ANG_TWO_PI);
        end
        else
        begin
            a1 = a0;
        end
        if (a1 > AW'(ANG_HALF_PI))
        begin
            a2 = a1 - AW'(ANG_PI);
            fold_neg = 1'b1;
        end
        else if (a1 < -AW'(ANG_HALF_PI))
        begin
            a2 = a1 + AW'(ANG_PI);
            fold_neg = 1'b1;
        end
        else
        begin
            a2 = a1;
            fold_neg = 1'b0;
        end
        z_ext = ZW'(a2);
        fold_next.x   = GAIN_Q30;
        fold_next.y   = '0;
        fold_next.z   = z_ext <<< ZFRAC;
        fold_next.neg = fold_neg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
        end
        else
        begin
            fold_valid_reg <= mod_v[MOD_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        fold_tok_reg <= fold_next;
    end

    assign cv[0] = fold_valid_reg;
    assign ct[0] = fold_tok_reg;

    for (genvar s = 0; s < CORDIC_STAGES; s++)
    begin : g_cordic
        ape_cordic_cell #(
            .STAGE(s)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid_in (cv[s]),
            .tok_in   (ct[s]),
            .valid_out(cv[s+1]),
            .tok_out  (ct[s+1])
        );
    end

    ape_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (cv[CORDIC_STAGES]),
        .tok_in     (ct[CORDIC_STAGES]),
        .radius     (radius_reg),
        .axes_packed(axes_reg),
        .center_x   (center_x_reg),
        .center_y   (center_y_reg),
        .done       (done),
        .point_x    (point_x),
        .point_y    (point_y)
    );

    `APE_ASSERT_IMPL(a_done_latency, clk, rst_n, done, $past(start && !busy, LAT))
    `APE_ASSERT_IMPL(a_mod_range, clk, rst_n, mod_v[MOD_STEPS], mod_r[MOD_STEPS] < MW'(ANG_TWO_PI))
    `APE_ASSERT_NEVER(a_fold_range, clk, rst_n, cv[0] && (ct[0].z > Z_LIM || ct[0].z < -Z_LIM))

endmodule
